/* hdl/tle_pkg.sv */
package tle_pkg;

    // Line store geometry.
    localparam int STORE_DEPTH  = 32;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int COUNT_W      = 5;
    localparam int LINE_MAX_DEF = 32;

    // Received byte codes.
    localparam logic [7:0] CH_IAC   = 8'hFF;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ETX   = 8'h03;

    // Result word kinds.
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // IAC drops itself and the next two bytes.
    localparam logic [1:0] IAC_SKIP = 2'd2;

    // Cancel message: "^C", CR, LF, "ready> ".
    localparam logic [3:0] CANCEL_LEN = 4'd11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_BKSP,
        ST_CRLF,
        ST_LINE,
        ST_END,
        ST_CANCEL
    } tle_state_t;

    // Access to the line store for one cycle.
    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic [STORE_AW-1:0] raddr;
    } tle_mem_req_t;

    function automatic logic [7:0] cancel_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h5E;
            4'd1:    b = 8'h43;
            4'd2:    b = 8'h0D;
            4'd3:    b = 8'h0A;
            4'd4:    b = 8'h72;
            4'd5:    b = 8'h65;
            4'd6:    b = 8'h61;
            4'd7:    b = 8'h64;
            4'd8:    b = 8'h79;
            4'd9:    b = 8'h3E;
            default: b = 8'h20;
        endcase
        return b;
    endfunction

endpackage

/* hdl/tle_line_mem.sv */
module tle_line_mem (
    input  logic                 clk,
    input  tle_pkg::tle_mem_req_t req,
    output logic [7:0]           rd_data
);
    import tle_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    // Single write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/tle_ctrl.sv */
module tle_ctrl #(
    parameter int LINE_MAX = tle_pkg::LINE_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [7:0]            in_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            out_kind,
    output logic [7:0]            out_byte,
    output logic [4:0]            line_length,
    output logic                  last,
    output tle_pkg::tle_mem_req_t mem_req,
    input  logic [7:0]            mem_rd_data
);
    import tle_pkg::*;

    // A line holds at most LINE_MAX-1 characters and never more than 31.
    localparam int CapRaw = LINE_MAX - 1;
    localparam logic [COUNT_W-1:0] LineCap = COUNT_W'((CapRaw > 31) ? 31 : CapRaw);

    tle_state_t         state_reg, state_next;
    logic [3:0]         step_reg, step_next;
    logic [7:0]         char_reg, char_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [1:0]         skip_reg, skip_next;
    logic [COUNT_W-1:0] len_reg, len_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_kind_reg, out_kind_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic [COUNT_W-1:0] out_len_reg, out_len_next;
    logic               out_last_reg, out_last_next;

    logic slot_free;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            skip_reg      <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            skip_reg      <= skip_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the pending echo and of the output word.
    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    assign slot_free = !out_valid_reg || !out_stall;

    // Decode of a received byte and the sequencer that emits result words.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        char_next      = char_reg;
        count_next     = count_reg;
        skip_next      = skip_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        mem_req.we     = 1'b0;
        mem_req.waddr  = count_reg;
        mem_req.wdata  = in_byte;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode)
                    begin
                        count_next = '0;
                        skip_next  = '0;
                    end
                    else if (skip_reg != 2'd0)
                    begin
                        skip_next = skip_reg - 2'd1;
                    end
                    else if (in_byte == CH_IAC)
                    begin
                        skip_next = IAC_SKIP;
                    end
                    else if (in_byte >= CH_SPACE && in_byte <= CH_TILDE)
                    begin
                        if (count_reg < LineCap)
                        begin
                            mem_req.we = 1'b1;
                            count_next = count_reg + 5'd1;
                            char_next  = in_byte;
                            state_next = ST_CHAR;
                        end
                    end
                    else if (in_byte == CH_BS || in_byte == CH_DEL)
                    begin
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 5'd1;
                            step_next  = '0;
                            state_next = ST_BKSP;
                        end
                    end
                    else if (in_byte == CH_CR)
                    begin
                        len_next   = count_reg;
                        count_next = '0;
                        step_next  = '0;
                        idx_next   = '0;
                        state_next = ST_CRLF;
                    end
                    else if (in_byte == CH_ETX)
                    begin
                        count_next = '0;
                        step_next  = '0;
                        state_next = ST_CANCEL;
                    end
                end
            end

            ST_CHAR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ECHO;
                    out_byte_next  = char_reg;
                    out_len_next   = '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_BKSP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ECHO;
                    out_byte_next  = (step_reg == 4'd1) ? CH_SPACE : CH_BS;
                    out_len_next   = '0;
                    out_last_next  = (step_reg == 4'd2);
                    step_next      = step_reg + 4'd1;
                    if (step_reg == 4'd2)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_CRLF:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ECHO;
                    out_byte_next  = (step_reg == 4'd0) ? CH_CR : CH_LF;
                    out_len_next   = '0;
                    out_last_next  = 1'b0;
                    step_next      = step_reg + 4'd1;
                    if (step_reg == 4'd1)
                    begin
                        state_next = (len_reg != '0) ? ST_LINE : ST_END;
                    end
                end
            end

            ST_LINE:
            begin
                // The read data always holds the entry at idx_reg.
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_CHAR;
                    out_byte_next  = mem_rd_data;
                    out_len_next   = '0;
                    out_last_next  = 1'b0;
                    idx_next       = idx_reg + 5'd1;
                    if (idx_reg + 5'd1 == len_reg)
                    begin
                        state_next = ST_END;
                    end
                end
            end

            ST_END:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_END;
                    out_byte_next  = '0;
                    out_len_next   = len_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_CANCEL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ECHO;
                    out_byte_next  = cancel_byte(step_reg);
                    out_len_next   = '0;
                    out_last_next  = (step_reg == CANCEL_LEN - 4'd1);
                    step_next      = step_reg + 4'd1;
                    if (step_reg == CANCEL_LEN - 4'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Read ahead so that the data lines up with idx_reg next cycle.
        mem_req.raddr = idx_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_byte    = out_byte_reg;
    assign line_length = out_len_reg;
    assign last        = out_last_reg;

endmodule

/* hdl/telnet_line_editor_core.sv */
// Channel | Handshake           | Word
// --------+---------------------+----------------------------------------
// input   | in_valid / in_stall | mode, in_byte
// output  | out_valid/out_stall | out_kind, out_byte, line_length, last
//
// One input word is taken at a time. A printable character gives its echo while the line has room,
// a non-empty line's backspace BS, space, BS, Ctrl-C the cancel message, and CR echoes CR, LF,
// then the line, one result word per cycle from the line store while no stall
// holds the output, then a line end. The sequencer has a single output register.
// Reset (rst_n low, asynchronous) empties the line and the IAC skip count.
// A stall on the output holds the sequencer; the input stays stalled until
// the last result word of the current input has been loaded.
module telnet_line_editor_core #(
    parameter int LINE_MAX = tle_pkg::LINE_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       mode,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] out_kind,
    output logic [7:0] out_byte,
    output logic [4:0] line_length,
    output logic       last
);
    import tle_pkg::*;

    tle_mem_req_t mem_req;
    logic [7:0]   mem_rd_data;

    // Line editing state machine with the output register.
    tle_ctrl #(
        .LINE_MAX (LINE_MAX)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_kind    (out_kind),
        .out_byte    (out_byte),
        .line_length (line_length),
        .last        (last),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    // Line store.
    tle_line_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

endmodule

/* hdl/tle_checker.sv */
module tle_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] out_kind,
    input logic [7:0] out_byte,
    input logic [4:0] line_length,
    input logic       last
);
    import tle_pkg::*;

    // A stalled output word stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind))
    else $error("output word changed while stalled");

    // While words of one input are still due, no new input is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
    else $error("input open before the last result word");

    // A line end closes its input and carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_END |-> last && out_byte == 8'd0)
    else $error("line end word malformed");

    // A line character never closes its input and carries no line length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_CHAR |-> !last && line_length == 5'd0)
    else $error("line character word malformed");

endmodule

bind telnet_line_editor_core tle_checker u_tle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_byte    (out_byte),
    .line_length (line_length),
    .last        (last)
);
